// ===== rtl/core/obbot_pkg.sv =====
// shared constants, types and helpers for the oriented box overlap test
`default_nettype none
package obbot_pkg;

   localparam int AXIS_FRAC_BITS = 14;
   localparam int COORD_BITS     = 20;
   localparam int LENGTH_BITS    = 16;

   localparam int AXW     = AXIS_FRAC_BITS + 2;
   localparam int MAGW    = AXIS_FRAC_BITS + 1;
   localparam int RPROD_W = 2 * AXW;
   localparam int RSUM_W  = RPROD_W + 2;
   localparam int TPROD_W = AXW + COORD_BITS;
   localparam int TSUM_W  = TPROD_W + 2;
   localparam int MQP_W   = TSUM_W + MAGW;
   localparam int MQ_W    = TSUM_W + 2;
   localparam int LPROD_W = LENGTH_BITS + MAGW;
   localparam int RHS_W   = LPROD_W + 2;
   localparam int CMP_W   = ((MQ_W + 3) > RHS_W ? (MQ_W + 3) : RHS_W) + 1;

   localparam int REQ_BITS = 6 * 3 * AXW + 3 * COORD_BITS + 6 * LENGTH_BITS;
   localparam int REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_W    = 8;
   localparam int QDEPTH   = 4;
   localparam int QPTR_W   = $clog2(QDEPTH);

   localparam logic signed [AXW-1:0] ONE_Q  = AXW'(1 << AXIS_FRAC_BITS);
   localparam logic [RSUM_W-1:0]     HALF_R = RSUM_W'(1 << (AXIS_FRAC_BITS - 1));
   localparam logic [MQP_W-1:0]      HALF_M = MQP_W'(1 << (AXIS_FRAC_BITS - 1));

   typedef struct packed {
      logic [2:0][2:0][AXW-1:0]   a;
      logic [2:0][2:0][AXW-1:0]   b;
      logic [2:0][COORD_BITS-1:0] d;
      logic [2:0][LENGTH_BITS-1:0] la;
      logic [2:0][LENGTH_BITS-1:0] lb;
   } box_pair_type;

   function automatic logic [AXW-1:0] clamp_unit(input logic [AXW-1:0] v);
      logic signed [AXW-1:0] sv;
      sv = $signed(v);
      if (sv > ONE_Q) return ONE_Q;
      if (sv < -ONE_Q) return -ONE_Q;
      return v;
   endfunction

   // q2f to qf, half away from zero, then limited to unit range
   function automatic logic [AXW-1:0] round_clamp(input logic signed [RSUM_W-1:0] x);
      logic [RSUM_W-1:0] m;
      logic [RSUM_W-1:0] q;
      m = x[RSUM_W-1] ? RSUM_W'(-x) : RSUM_W'(x);
      q = (m + HALF_R) >> AXIS_FRAC_BITS;
      if (q > RSUM_W'(ONE_Q)) q = RSUM_W'(ONE_Q);
      return x[RSUM_W-1] ? AXW'(-q) : AXW'(q);
   endfunction

   function automatic int nxt(input int i);
      return (i == 2) ? 0 : i + 1;
   endfunction

   function automatic box_pair_type unpack_pair(input logic [REQ_W-1:0] w);
      box_pair_type p;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            p.a[i][k] = clamp_unit(w[(i * 3 + k) * AXW +: AXW]);
            p.b[i][k] = clamp_unit(w[((3 + i) * 3 + k) * AXW +: AXW]);
         end
         p.d[i]  = w[18 * AXW + i * COORD_BITS +: COORD_BITS];
         p.la[i] = w[18 * AXW + 3 * COORD_BITS + i * LENGTH_BITS +: LENGTH_BITS];
         p.lb[i] = w[18 * AXW + 3 * COORD_BITS + (3 + i) * LENGTH_BITS +: LENGTH_BITS];
      end
      return p;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/obb_overlap_test_top.sv =====
// top level of the oriented box overlap test
`default_nettype none
// Oriented box overlap test, 15-axis separating axis test. Each item on
// the req_ channel is one pair of boxes; each gives exactly one item on
// rsp_ with overlap in bit 0 (1 = no separating axis found, touching counts
// as overlap). When nothing stalls, one item is taken every cycle. Each item
// passes in turn through the front register, the queue and the back
// pipeline (products, rotation sums and rounding, magnitude products,
// rounding and right-hand sides, compare). The front stage and a
// four-entry queue keep taking items, until the queue is full, while the
// back pipeline is held by a stalled rsp_ channel. Nothing is stored
// between items.
module obb_overlap_test_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_tvalid,
   output logic                              req_tready,
   // from bit 0: box_a_axis_0, box_a_axis_1, box_a_axis_2, box_b_axis_0,
   // box_b_axis_1, box_b_axis_2 (48 each), center_offset (60),
   // box_a_lengths, box_b_lengths (48 each), zero fill
   input  wire logic [obbot_pkg::REQ_W-1:0]  req_tdata,
   output logic                              rsp_tvalid,
   input  wire logic                         rsp_tready,
   // bit 0: overlap, rest zero
   output logic [obbot_pkg::RSP_W-1:0]       rsp_tdata
);
   logic                    push, q_ready, q_valid, pop;
   obbot_pkg::box_pair_type push_data, pop_data;

   // unpack and clamp the axis components
   obbot_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .push       (push),
      .q_ready    (q_ready),
      .push_data  (push_data)
   );

   // decouples the front from back-pressure on the result side
   obbot_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .q_ready   (q_ready),
      .push_data (push_data),
      .pop       (pop),
      .q_valid   (q_valid),
      .pop_data  (pop_data)
   );

   // arithmetic pipeline, holds as a whole while the result waits
   obbot_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_data     (pop_data),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );
endmodule
`default_nettype wire

// ===== rtl/core/obbot_front.sv =====
// front end: accepts items, unpacks and clamps the fields
`default_nettype none
module obbot_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   input  wire logic [obbot_pkg::REQ_W-1:0]   req_tdata,
   output logic                               push,
   input  wire logic                          q_ready,
   output obbot_pkg::box_pair_type            push_data
);
   logic                    valid_ff, valid_in;
   obbot_pkg::box_pair_type data_ff;

   assign req_tready = !valid_ff || q_ready;
   assign push       = valid_ff && q_ready;
   assign push_data  = data_ff;
   assign valid_in   = (req_tvalid && req_tready) || (valid_ff && !q_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         data_ff <= obbot_pkg::unpack_pair(req_tdata);
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/obbot_queue.sv =====
// short queue between front and back
`default_nettype none
module obbot_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     push,
   output logic                          q_ready,
   input  wire obbot_pkg::box_pair_type  push_data,
   input  wire logic                     pop,
   output logic                          q_valid,
   output obbot_pkg::box_pair_type       pop_data
);
   obbot_pkg::box_pair_type             mem_ff [obbot_pkg::QDEPTH];
   logic [obbot_pkg::QPTR_W-1:0]        wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [obbot_pkg::QPTR_W:0]          count_ff, count_in;

   assign q_ready  = count_ff != (obbot_pkg::QPTR_W + 1)'(obbot_pkg::QDEPTH);
   assign q_valid  = count_ff != '0;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (pop && q_valid) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + (obbot_pkg::QPTR_W + 1)'(push)
                  - (obbot_pkg::QPTR_W + 1)'(pop && q_valid);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/obbot_back.sv =====
// back end: five-stage pipeline of the separating axis test
`default_nettype none
module obbot_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     q_valid,
   input  wire obbot_pkg::box_pair_type  q_data,
   output logic                          pop,
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [obbot_pkg::RSP_W-1:0]   rsp_tdata
);
   localparam int F = obbot_pkg::AXIS_FRAC_BITS;
   localparam int LW = obbot_pkg::LENGTH_BITS;

   logic adv;
   logic v1_ff, v2_ff, v3_ff, v4_ff, out_valid_ff, overlap_ff, overlap_in;

   // stage 1: raw products
   logic signed [obbot_pkg::RPROD_W-1:0] pr1_ff [3][3][3], pr1_in [3][3][3];
   logic signed [obbot_pkg::TPROD_W-1:0] pt1_ff [3][3], pt1_in [3][3];
   logic [LW-1:0] la1_ff [3], lb1_ff [3];
   // stage 2: rotation terms and projected offset
   logic signed [obbot_pkg::AXW-1:0]    r2_ff [3][3], r2_in [3][3];
   logic signed [obbot_pkg::TSUM_W-1:0] t2_ff [3], t2_in [3];
   logic [LW-1:0] la2_ff [3], lb2_ff [3];
   // stage 3: products on magnitudes
   logic [obbot_pkg::MQP_W-1:0]   mqp3_ff [3][3][3], mqp3_in [3][3][3];
   logic                          mqn3_ff [3][3][3], mqn3_in [3][3][3];
   logic [obbot_pkg::LPROD_W-1:0] lar3_ff [3][3][3], lar3_in [3][3][3];
   logic [obbot_pkg::LPROD_W-1:0] lbr3_ff [3][3][3], lbr3_in [3][3][3];
   logic [obbot_pkg::TSUM_W-1:0]  at3_ff [3], at3_in [3];
   logic [LW-1:0] la3_ff [3], lb3_ff [3];
   // stage 4: rounded products, right-hand sides
   logic signed [obbot_pkg::MQ_W-1:0]  mq4_ff [3][3][3], mq4_in [3][3][3];
   logic signed [obbot_pkg::CMP_W-1:0] rhs4_ff [15], rhs4_in [15];
   logic signed [obbot_pkg::CMP_W-1:0] lhsa4_ff [3], lhsa4_in [3];

   assign adv        = !out_valid_ff || rsp_tready;
   assign pop        = q_valid && adv;
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(obbot_pkg::RSP_W - 1)'(0), overlap_ff};

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            for (int k = 0; k < 3; k++) begin
               pr1_in[i][j][k] = obbot_pkg::RPROD_W'($signed(q_data.a[i][k])
                                 * $signed(q_data.b[j][k]));
            end
         end
         for (int k = 0; k < 3; k++) begin
            pt1_in[i][k] = obbot_pkg::TPROD_W'($signed(q_data.a[i][k])
                           * $signed(q_data.d[k]));
         end
      end
   end

   always_comb begin
      logic signed [obbot_pkg::RSUM_W-1:0] s;
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            s = obbot_pkg::RSUM_W'(pr1_ff[i][j][0]) + obbot_pkg::RSUM_W'(pr1_ff[i][j][1])
                + obbot_pkg::RSUM_W'(pr1_ff[i][j][2]);
            r2_in[i][j] = $signed(obbot_pkg::round_clamp(s));
         end
         t2_in[i] = obbot_pkg::TSUM_W'(pt1_ff[i][0]) + obbot_pkg::TSUM_W'(pt1_ff[i][1])
                    + obbot_pkg::TSUM_W'(pt1_ff[i][2]);
      end
   end

   always_comb begin
      logic [obbot_pkg::TSUM_W-1:0] mt;
      logic [obbot_pkg::MAGW-1:0]   mr;
      for (int k = 0; k < 3; k++) begin
         mt = t2_ff[k][obbot_pkg::TSUM_W-1] ? obbot_pkg::TSUM_W'(-t2_ff[k])
                                            : obbot_pkg::TSUM_W'(t2_ff[k]);
         at3_in[k] = mt;
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               mr = r2_ff[m][j][obbot_pkg::AXW-1] ? obbot_pkg::MAGW'(-r2_ff[m][j])
                                                  : obbot_pkg::MAGW'(r2_ff[m][j]);
               mqp3_in[k][m][j] = obbot_pkg::MQP_W'(mt) * obbot_pkg::MQP_W'(mr);
               mqn3_in[k][m][j] = t2_ff[k][obbot_pkg::TSUM_W-1]
                                  ^ r2_ff[m][j][obbot_pkg::AXW-1];
               lar3_in[k][m][j] = obbot_pkg::LPROD_W'(la2_ff[k]) * obbot_pkg::LPROD_W'(mr);
               lbr3_in[k][m][j] = obbot_pkg::LPROD_W'(lb2_ff[k]) * obbot_pkg::LPROD_W'(mr);
            end
         end
      end
   end

   always_comb begin
      logic [obbot_pkg::MQP_W-1:0] q;
      int p1, p2, q1, q2;
      for (int k = 0; k < 3; k++) begin
         for (int m = 0; m < 3; m++) begin
            for (int j = 0; j < 3; j++) begin
               q = (mqp3_ff[k][m][j] + obbot_pkg::HALF_M) >> F;
               mq4_in[k][m][j] = mqn3_ff[k][m][j] ? -$signed(obbot_pkg::MQ_W'(q))
                                                  : $signed(obbot_pkg::MQ_W'(q));
            end
         end
      end
      for (int i = 0; i < 3; i++) begin
         lhsa4_in[i] = $signed(obbot_pkg::CMP_W'(at3_ff[i]) << 1);
         // own axes of a
         rhs4_in[i] = $signed((obbot_pkg::CMP_W'(la3_ff[i]) << F)
                      + obbot_pkg::CMP_W'(lbr3_ff[0][i][0])
                      + obbot_pkg::CMP_W'(lbr3_ff[1][i][1])
                      + obbot_pkg::CMP_W'(lbr3_ff[2][i][2]));
         // own axes of b
         rhs4_in[3 + i] = $signed((obbot_pkg::CMP_W'(lb3_ff[i]) << F)
                          + obbot_pkg::CMP_W'(lar3_ff[0][0][i])
                          + obbot_pkg::CMP_W'(lar3_ff[1][1][i])
                          + obbot_pkg::CMP_W'(lar3_ff[2][2][i]));
      end
      for (int i = 0; i < 3; i++) begin
         p1 = obbot_pkg::nxt(i);
         p2 = obbot_pkg::nxt(p1);
         for (int j = 0; j < 3; j++) begin
            q1 = obbot_pkg::nxt(j);
            q2 = obbot_pkg::nxt(q1);
            rhs4_in[6 + i * 3 + j] = $signed(obbot_pkg::CMP_W'(lar3_ff[p1][p2][j])
                                     + obbot_pkg::CMP_W'(lar3_ff[p2][p1][j])
                                     + obbot_pkg::CMP_W'(lbr3_ff[q1][i][q2])
                                     + obbot_pkg::CMP_W'(lbr3_ff[q2][i][q1]));
         end
      end
   end

   always_comb begin
      logic signed [obbot_pkg::CMP_W-1:0] p;
      logic signed [obbot_pkg::CMP_W-1:0] lhs;
      logic sep;
      int p1, p2;
      sep = 1'b0;
      for (int i = 0; i < 3; i++) begin
         if (lhsa4_ff[i] > rhs4_ff[i]) sep = 1'b1;
      end
      for (int j = 0; j < 3; j++) begin
         p = obbot_pkg::CMP_W'(mq4_ff[0][0][j]) + obbot_pkg::CMP_W'(mq4_ff[1][1][j])
             + obbot_pkg::CMP_W'(mq4_ff[2][2][j]);
         lhs = (p < 0) ? -(p <<< 1) : (p <<< 1);
         if (lhs > rhs4_ff[3 + j]) sep = 1'b1;
      end
      for (int i = 0; i < 3; i++) begin
         p1 = obbot_pkg::nxt(i);
         p2 = obbot_pkg::nxt(p1);
         for (int j = 0; j < 3; j++) begin
            p = obbot_pkg::CMP_W'(mq4_ff[p2][p1][j]) - obbot_pkg::CMP_W'(mq4_ff[p1][p2][j]);
            lhs = (p < 0) ? -(p <<< 1) : (p <<< 1);
            if (lhs > rhs4_ff[6 + i * 3 + j]) sep = 1'b1;
         end
      end
      overlap_in = !sep;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         out_valid_ff <= v4_ff;
      end
      if (adv) begin
         pr1_ff     <= pr1_in;
         pt1_ff     <= pt1_in;
         r2_ff      <= r2_in;
         t2_ff      <= t2_in;
         mqp3_ff    <= mqp3_in;
         mqn3_ff    <= mqn3_in;
         lar3_ff    <= lar3_in;
         lbr3_ff    <= lbr3_in;
         at3_ff     <= at3_in;
         mq4_ff     <= mq4_in;
         rhs4_ff    <= rhs4_in;
         lhsa4_ff   <= lhsa4_in;
         overlap_ff <= overlap_in;
         for (int i = 0; i < 3; i++) begin
            la1_ff[i] <= q_data.la[i];
            lb1_ff[i] <= q_data.lb[i];
            la2_ff[i] <= la1_ff[i];
            lb2_ff[i] <= lb1_ff[i];
            la3_ff[i] <= la2_ff[i];
            lb3_ff[i] <= lb2_ff[i];
         end
      end
   end
endmodule
`default_nettype wire

// ===== rtl/core/obbot_checker.sv =====
// port-level checks for the overlap test top level
`default_nettype none
module obbot_checker (
   input wire logic                       clock,
   input wire logic                       reset,
   input wire logic                       rsp_tvalid,
   input wire logic                       rsp_tready,
   input wire logic [obbot_pkg::RSP_W-1:0] rsp_tdata
);
   a_rst_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   a_pad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[obbot_pkg::RSP_W-1:1] == '0)
      else $error("result fill bits not zero");

   a_valid_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result dropped while stalled");

   a_data_holds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_early_rsp: assert property (@(posedge clock)
      $past(reset) && !reset |-> !rsp_tvalid)
      else $error("result right out of reset");
endmodule

bind obb_overlap_test_top obbot_checker u_checker (.*);
`default_nettype wire
